// File: rtl/char_stream_tokenizer_unit_assert.svh
// Assertion macros used by the checker of the tokenizer.
`ifndef CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  localparam int CST_MAX_LEXEME = 32;

  // scan modes
  localparam logic [2:0] M_START  = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_OPER   = 3'd3;
  localparam logic [2:0] M_PAREN  = 3'd4;

  // token kinds
  localparam logic [3:0] K_UNKNOWN = 4'd0;
  localparam logic [3:0] K_IDENT   = 4'd1;
  localparam logic [3:0] K_INT     = 4'd2;
  localparam logic [3:0] K_LPAREN  = 4'd3;
  localparam logic [3:0] K_RPAREN  = 4'd4;
  localparam logic [3:0] K_ASSIGN  = 4'd5;
  localparam logic [3:0] K_ADD     = 4'd6;
  localparam logic [3:0] K_SUB     = 4'd7;
  localparam logic [3:0] K_MUL     = 4'd8;
  localparam logic [3:0] K_DIV     = 4'd9;
  localparam logic [3:0] K_DELIM   = 4'd10;
  localparam logic [3:0] K_BAD     = 4'd11;
  localparam logic [3:0] K_END     = 4'd12;

  // characters
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_EQ         = 8'h3D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  // what one input beat does to the scanner
  typedef struct packed {
    logic       eoi;
    logic       flush;
    logic       push;
    logic       bad;
    logic       newline;
    logic       semi;
    logic [2:0] mode;
    logic [7:0] chr;
  } act_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  lexeme_byte;
    logic        last;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] stmt;
    logic        trunc;
  } out_item_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oper(logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ};
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [3:0] classify(logic single, logic all_digits, logic [7:0] first);
    logic [3:0] k;
    k = K_UNKNOWN;
    if (single) begin
      if (is_digit(first)) k = K_INT;
      else if (is_letter(first)) k = K_IDENT;
      else begin
        case (first)
          CH_LPAREN: k = K_LPAREN;
          CH_RPAREN: k = K_RPAREN;
          CH_EQ:     k = K_ASSIGN;
          CH_PLUS:   k = K_ADD;
          CH_MINUS:  k = K_SUB;
          CH_STAR:   k = K_MUL;
          CH_SLASH:  k = K_DIV;
          CH_SEMI:   k = K_DELIM;
          default:   k = K_UNKNOWN;
        endcase
      end
    end else if (all_digits) begin
      k = K_INT;
    end else if (is_letter(first)) begin
      k = K_IDENT;
    end
    return k;
  endfunction

  function automatic act_t decode(logic [7:0] c, logic eoi, logic [2:0] mode);
    act_t       a;
    logic [2:0] m;
    logic       in_word;
    m       = (mode > M_PAREN) ? M_START : mode;
    in_word = (m == M_IDENT) || (m == M_NUMBER);
    a       = '0;
    a.chr   = c;
    a.mode  = M_START;
    if (eoi) begin
      a.eoi   = 1'b1;
      a.flush = 1'b1;
    end else if (is_space(c)) begin
      a.flush   = 1'b1;
      a.newline = (c == CH_LF);
    end else if (c == CH_SEMI) begin
      a.flush = 1'b1;
      a.push  = 1'b1;
      a.semi  = 1'b1;
    end else if (is_letter(c) || c == CH_UNDERSCORE) begin
      a.flush = !in_word;
      a.push  = 1'b1;
      a.mode  = M_IDENT;
    end else if (is_digit(c)) begin
      a.flush = !in_word;
      a.push  = 1'b1;
      a.mode  = in_word ? m : M_NUMBER;
    end else if (is_oper(c)) begin
      a.flush = (m != M_OPER);
      a.push  = 1'b1;
      a.mode  = M_OPER;
    end else if (c == CH_LPAREN || c == CH_RPAREN) begin
      a.flush = 1'b1;
      a.push  = 1'b1;
      a.mode  = M_PAREN;
    end else begin
      a.flush = 1'b1;
      a.bad   = 1'b1;
    end
    return a;
  endfunction

endpackage

// File: rtl/cst_ram.sv
`timescale 1ns / 1ps

module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/cst_emit.sv
`timescale 1ns / 1ps

module cst_emit import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  out_item_t   item,
  output logic        free,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic [4:0]  out_tuser,
  output logic        out_tlast
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // register may take a new beat when empty or being drained this cycle
  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {item_r.stmt, item_r.col, item_r.row, item_r.lexeme_byte};
  assign out_tuser  = {item_r.trunc, item_r.kind};
  assign out_tlast  = item_r.last;

endmodule

// File: rtl/char_stream_tokenizer_unit.sv
// A byte that closes no lexeme and is not illegal sends no beat.
// A byte that closes an N-byte lexeme does one read lead-in from the lexeme store,
// then one beat per cycle set by its single read port, unless the output stalls.
// An illegal byte or the end beat adds its own result beat.
// rst_n is synchronous, active low: mode, length and counters clear at once; the
// lexeme store is not cleared, it is only read below the current length.
`timescale 1ns / 1ps

module char_stream_tokenizer_unit import cst_pkg::*; #(
  parameter int MAX_LEXEME = CST_MAX_LEXEME
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] lexeme_byte, [23:8] token_row,
                                  // [39:24] token_column, [55:40] statement_count
  output logic [4:0]  out_tuser,  // [3:0] kind, [4] lexeme_truncated
  output logic        out_tlast   // last_of_run
);

  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int IDX_W = $clog2(MAX_LEXEME);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEXEME);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [15:0]      row_r, row_nxt;
  logic [15:0]      col_r, col_nxt;
  logic [15:0]      stmt_r, stmt_nxt;
  logic             ad_r, ad_nxt;
  logic             ov_r, ov_nxt;
  logic             pend_r, pend_nxt;
  logic [7:0]       first_r, first_nxt;
  act_t             act_r;
  logic [3:0]       kind_r;

  act_t             act_in, fin_act;
  logic             accept, need_flush_in, need_out_in;
  logic             load_ram, flush_done, emit_extra, fin_en, tail_beat;
  logic             rd_en, wr_en, out_free;
  logic [IDX_W-1:0] wr_addr;
  logic [LEN_W-1:0] base_len;
  logic [7:0]       ram_q;
  out_item_t        item;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    accept        = in_tvalid && in_tready;
    act_in        = decode(in_tdata, in_tlast, mode_r);
    need_flush_in = act_in.flush && (len_r != '0);
    need_out_in   = need_flush_in || act_in.bad || act_in.eoi;
    tail_beat     = act_r.bad || act_r.eoi;

    // RAM data is the byte at rd_idx_r-1; it moves out when the output stage frees
    load_ram   = (state_r == S_FLUSH) && pend_r && out_free;
    flush_done = load_ram && (rd_idx_r == len_r);
    rd_en      = (state_r == S_FLUSH) && (rd_idx_r != len_r) && (!pend_r || load_ram);
    emit_extra = (state_r == S_EMIT) && out_free;

    fin_en  = (accept && !need_out_in) || (flush_done && !tail_beat) || emit_extra;
    fin_act = (state_r == S_IDLE) ? act_in : act_r;

    item.row  = row_r;
    item.col  = col_r;
    item.stmt = stmt_r;
    if (state_r == S_EMIT) begin
      item.kind        = act_r.eoi ? K_END : K_BAD;
      item.lexeme_byte = act_r.eoi ? 8'h00 : act_r.chr;
      item.last        = 1'b1;
      item.trunc       = 1'b0;
    end else begin
      item.kind        = kind_r;
      item.lexeme_byte = ram_q;
      item.last        = (rd_idx_r == len_r) && !tail_beat;
      item.trunc       = ov_r;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    rd_idx_nxt = rd_idx_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    stmt_nxt   = stmt_r;
    ad_nxt     = ad_r;
    ov_nxt     = ov_r;
    first_nxt  = first_r;
    pend_nxt   = pend_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    base_len   = len_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && need_out_in) begin
          state_nxt = need_flush_in ? S_FLUSH : S_EMIT;
        end
      end
      S_FLUSH: begin
        if (flush_done) begin
          state_nxt = tail_beat ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (accept) begin
      rd_idx_nxt = '0;
      if (!act_in.eoi) begin
        col_nxt = sat_inc(col_r);
      end
    end
    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + LEN_ONE;
      pend_nxt   = 1'b1;
    end else if (load_ram) begin
      pend_nxt = 1'b0;
    end

    // commit the beat's effect once all of its results are out
    if (fin_en) begin
      if (fin_act.eoi) begin
        mode_nxt = M_START;
        len_nxt  = '0;
        row_nxt  = '0;
        col_nxt  = '0;
        stmt_nxt = '0;
        ad_nxt   = 1'b1;
        ov_nxt   = 1'b0;
      end else begin
        if (fin_act.flush) begin
          base_len = '0;
          ad_nxt   = 1'b1;
          ov_nxt   = 1'b0;
        end
        len_nxt = base_len;
        if (fin_act.push) begin
          if (base_len < LEN_MAX) begin
            wr_en   = 1'b1;
            wr_addr = base_len[IDX_W-1:0];
            len_nxt = base_len + LEN_ONE;
            if (!is_digit(fin_act.chr)) ad_nxt = 1'b0;
            if (base_len == '0) first_nxt = fin_act.chr;
          end else begin
            ov_nxt = 1'b1;
          end
        end
        if (fin_act.newline) begin
          row_nxt = sat_inc(row_r);
          col_nxt = '0;
        end
        if (fin_act.semi) begin
          stmt_nxt = sat_inc(stmt_r);
        end
        mode_nxt = fin_act.mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_START;
      len_r    <= '0;
      rd_idx_r <= '0;
      row_r    <= '0;
      col_r    <= '0;
      stmt_r   <= '0;
      ad_r     <= 1'b1;
      ov_r     <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      rd_idx_r <= rd_idx_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      stmt_r   <= stmt_nxt;
      ad_r     <= ad_nxt;
      ov_r     <= ov_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    if (accept) begin
      act_r  <= act_in;
      kind_r <= classify(len_r == LEN_ONE, ad_r, first_r);
    end
  end

  cst_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEXEME)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (fin_act.chr),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (ram_q)
  );

  cst_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load_ram || emit_extra),
    .item       (item),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: rtl/cst_chk.sv
`timescale 1ns / 1ps
`include "char_stream_tokenizer_unit_assert.svh"

module cst_chk import cst_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  logic        stalled, eoi_acc, is_end, is_bad, end_ok, bad_ok;
  logic [61:0] beat;

  assign stalled = out_tvalid && !out_tready;
  assign eoi_acc = in_tvalid && in_tready && in_tlast;
  assign is_end  = out_tvalid && (out_tuser[3:0] == K_END);
  assign is_bad  = out_tvalid && (out_tuser[3:0] == K_BAD);
  assign end_ok  = out_tlast && (out_tdata[7:0] == 8'h00) && !out_tuser[4];
  assign bad_ok  = out_tlast && !out_tuser[4];
  assign beat    = {out_tdata, out_tuser, out_tlast};

  `CST_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable(beat), "beat not held")
  `CST_ASSERT_NOW(a_kind_range, clk, rst_n, out_tvalid, out_tuser[3:0] <= K_END, "bad kind")
  `CST_ASSERT_NOW(a_end_beat, clk, rst_n, is_end, end_ok, "end marker malformed")
  `CST_ASSERT_NOW(a_bad_beat, clk, rst_n, is_bad, bad_ok, "bad_char beat malformed")
  // an end beat always has at least its marker to send
  `CST_ASSERT_NEXT(a_end_blocks, clk, rst_n, eoi_acc, !in_tready, "input open after end beat")

endmodule

bind char_stream_tokenizer_unit cst_chk u_cst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
